@@ sv/aspect_circle_rasterizer_macros.svh @@
// Assertion macros for the aspect circle rasterizer.
// Used by acr_scaler and the top-level RTL; relies on clk and rst in the using module.
`ifndef ASPECT_CIRCLE_RASTERIZER_MACROS_SVH
`define ASPECT_CIRCLE_RASTERIZER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ACR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acr assertion failed");
// next-cycle implication
`define ACR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acr assertion failed");
`else
`define ACR_ASSERT_IMP(lbl, ante, cons)
`define ACR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ sv/acr_pkg.sv @@
// Shared types and constants for the aspect circle rasterizer.
// No dependencies; used by the interfaces and all RTL modules.
`timescale 1ns / 1ps

package acr_pkg;

  localparam int COORD_BITS_DEF = 8;   // default coordinate width
  localparam int FIELD_W        = 8;   // width of coordinate/radius fields
  localparam int CFG_W          = 8;   // width of aspect registers
  localparam int COLOR_W        = 4;
  localparam int POINT_W        = 10;  // signed output coordinate width
  localparam int PT_IDX_W       = 3;   // up to eight points per transaction
  localparam int CFG_IDX_W      = 1;

  // operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ASPECT_MULT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ASPECT_DIV  = 1'b1;

  // index of last point for each operation
  localparam logic [PT_IDX_W-1:0] START_LAST_IDX = 3'd3;
  localparam logic [PT_IDX_W-1:0] STEP_LAST_IDX  = 3'd7;

  // midpoint recurrence constants
  localparam int INCR_STEP  = 2;
  localparam int DECIS_INIT = 1;

  typedef struct packed {
    logic busy;
    logic done;
  } scl_stat_t;

  typedef struct packed {
    logic                load;
    logic                start_mode;
    logic [PT_IDX_W-1:0] idx;
    logic                last;
    logic                done;
  } pt_ctrl_t;

endpackage

@@ sv/acr_ifs.sv @@
// Channel interfaces of the aspect circle rasterizer: item, point, config.
// Depends on acr_pkg for field widths.
`timescale 1ns / 1ps

interface acr_item_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [acr_pkg::FIELD_W-1:0]  center_x;
  logic [acr_pkg::FIELD_W-1:0]  center_y;
  logic [acr_pkg::FIELD_W-1:0]  radius;
  logic [acr_pkg::COLOR_W-1:0]  color;

  modport source (output valid, operation, center_x, center_y, radius, color,
                  input ready);
  modport sink   (input valid, operation, center_x, center_y, radius, color,
                  output ready);
endinterface

interface acr_point_if;
  logic                               valid;
  logic                               ready;
  logic signed [acr_pkg::POINT_W-1:0] point_x;
  logic signed [acr_pkg::POINT_W-1:0] point_y;
  logic [acr_pkg::COLOR_W-1:0]        point_color;
  logic                               last_of_run;
  logic                               circle_done;

  modport source (output valid, point_x, point_y, point_color, last_of_run, circle_done,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_color, last_of_run, circle_done,
                  output ready);
endinterface

interface acr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [acr_pkg::CFG_IDX_W-1:0] index;
  logic [acr_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/acr_scaler.sv @@
// Shared aspect scaler: off * mult / div, one multiply then one quotient bit a cycle.
// Depends on acr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "aspect_circle_rasterizer_macros.svh"

module acr_scaler #(
  parameter int COORD_BITS = acr_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [COORD_BITS-1:0]       operand,
  input  logic [acr_pkg::CFG_W-1:0]   mult,
  input  logic [acr_pkg::CFG_W-1:0]   div,
  output acr_pkg::scl_stat_t          stat,
  output logic [COORD_BITS-1:0]       result
);

  localparam int PW = COORD_BITS + acr_pkg::CFG_W;
  localparam int CW = $clog2(COORD_BITS + 1);
  localparam int RW = acr_pkg::CFG_W;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_MUL  = 3'b010,
    PH_DIV  = 3'b100
  } phase_t;

  phase_t                phase;
  logic [COORD_BITS-1:0] opnd;
  logic [RW-1:0]         rem;
  logic [COORD_BITS-1:0] low;
  logic [CW-1:0]         cnt;
  logic                  done;
  logic                  enable;
  logic [RW:0]           trial;
  logic                  qbit;
  logic [RW-1:0]         rem_next;
  logic [PW-1:0]         prod;

  // scaling only when 0 < mult < div; quotient then never exceeds the operand
  assign enable = (mult != '0) && (div > mult);
  assign prod   = PW'(opnd) * PW'(mult);

  assign trial    = {rem, low[COORD_BITS-1]};
  assign qbit     = trial >= {1'b0, div};
  assign rem_next = qbit ? RW'(trial - {1'b0, div}) : trial[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      // result is ready after the bypass multiply cycle or the last quotient bit
      done <= ((phase == PH_MUL) && !enable) ||
              ((phase == PH_DIV) && (cnt == CW'(COORD_BITS - 1)));
      case (phase)
        PH_IDLE: begin
          if (start) begin
            opnd  <= operand;
            phase <= PH_MUL;
          end
        end
        PH_MUL: begin
          if (enable) begin
            // high part of product is below mult, hence below div
            rem   <= prod[PW-1:COORD_BITS];
            low   <= prod[COORD_BITS-1:0];
            cnt   <= '0;
            phase <= PH_DIV;
          end else begin
            result <= opnd;
            phase  <= PH_IDLE;
          end
        end
        PH_DIV: begin
          rem <= rem_next;
          low <= {low[COORD_BITS-2:0], qbit};
          cnt <= cnt + CW'(1);
          if (cnt == CW'(COORD_BITS - 1)) begin
            result <= {low[COORD_BITS-2:0], qbit};
            phase  <= PH_IDLE;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  assign stat.busy = (phase != PH_IDLE);
  assign stat.done = done;

  `ACR_ASSERT_IMP(a_rem_below_div, phase == PH_DIV, rem < div)
  `ACR_ASSERT_IMP(a_start_when_idle, start, phase == PH_IDLE)
  `ACR_ASSERT_NXT(a_done_then_idle, phase == PH_DIV && cnt == CW'(COORD_BITS - 1),
                  done && phase == PH_IDLE)

endmodule

@@ sv/acr_point_out.sv @@
// Point former and output register: builds one mirrored point per load.
// Depends on acr_pkg and acr_ifs.
`timescale 1ns / 1ps

module acr_point_out #(
  parameter int COORD_BITS = acr_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  acr_pkg::pt_ctrl_t             ctrl,
  input  logic [COORD_BITS-1:0]         cx,
  input  logic [COORD_BITS-1:0]         cy,
  input  logic [COORD_BITS-1:0]         hx,
  input  logic [COORD_BITS-1:0]         hy,
  input  logic [COORD_BITS-1:0]         vx,
  input  logic [COORD_BITS-1:0]         vy,
  input  logic [acr_pkg::COLOR_W-1:0]   color,
  output logic                          free,
  acr_point_if.source                   point
);

  localparam int SW = (COORD_BITS + 2 > acr_pkg::POINT_W) ? COORD_BITS + 2 : acr_pkg::POINT_W;

  logic                  valid;
  logic [COORD_BITS-1:0] h;
  logic [COORD_BITS-1:0] v;
  logic                  h_neg;
  logic                  v_neg;
  logic [SW-1:0]         px;
  logic [SW-1:0]         py;

  // start: axis points (0,+r) (0,-r) (+h,0) (-h,0)
  // step:  idx[2] picks octant pair, idx[0] horizontal sign, idx[1] vertical sign
  always_comb begin
    if (ctrl.start_mode) begin
      h     = ctrl.idx[1] ? hy : '0;
      v     = ctrl.idx[1] ? '0 : vy;
      v_neg = ctrl.idx[0];
    end else begin
      h     = ctrl.idx[2] ? hy : hx;
      v     = ctrl.idx[2] ? vx : vy;
      v_neg = ctrl.idx[1];
    end
    h_neg = ctrl.idx[0];
    px = h_neg ? SW'(cx) - SW'(h) : SW'(cx) + SW'(h);
    py = v_neg ? SW'(cy) - SW'(v) : SW'(cy) + SW'(v);
  end

  assign free = !valid || point.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.load) begin
      valid <= 1'b1;
    end else if (point.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      point.point_x     <= px[acr_pkg::POINT_W-1:0];
      point.point_y     <= py[acr_pkg::POINT_W-1:0];
      point.point_color <= color;
      point.last_of_run <= ctrl.last;
      point.circle_done <= ctrl.done;
    end
  end

  assign point.valid = valid;

endmodule

@@ sv/aspect_circle_rasterizer.sv @@
// Top level of the aspect circle rasterizer: sequencer, octant state, config.
// Depends on acr_pkg, acr_ifs, acr_scaler, acr_point_out and the macro header.
`timescale 1ns / 1ps
`include "aspect_circle_rasterizer_macros.svh"

// Midpoint circle rasterizer with horizontal aspect compression. A start
// transaction (operation 0) latches centre, radius and colour and yields four
// axis points: bottom, top, right, left. Each step transaction (operation 1)
// advances the octant by one and yields eight mirrored points; the last point
// of a transaction has last_of_run set, and circle_done marks the point after
// which no more steps remain (also a zero-radius start). A step with no circle
// in progress is accepted and yields nothing. Horizontal offsets are scaled by
// off*aspect_mult/aspect_div (truncated) when 0 < aspect_mult < aspect_div.
// One transaction at a time: item.ready is high only when idle. The cost
// is set by the single shared scaler, which per offset goes through launch,
// multiply, one quotient bit per cycle and hand-off, or through launch,
// multiply and hand-off with no quotient bits when scaling is off. A start
// needs one scaling, a step two, and then each point is loaded into the
// output register when it is free. Output stalls hold the point stream and,
// as item.ready waits for idle, also the intake of the next transaction.
// No clipping is done; coordinates wrap to 10 bits. Config writes are always
// accepted and should only happen while idle.

module aspect_circle_rasterizer #(
  parameter int COORD_BITS = acr_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  acr_cfg_if.sink     cfg,
  acr_item_if.sink    item,
  acr_point_if.source point
);

  localparam int DW = COORD_BITS + 4;  // decision term and increments, signed

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SCALE_H = 4'b0010,
    ST_SCALE_V = 4'b0100,
    ST_EMIT    = 4'b1000
  } state_t;

  state_t state;

  // config registers
  logic [acr_pkg::CFG_W-1:0] aspect_mult;
  logic [acr_pkg::CFG_W-1:0] aspect_div;

  // held circle and octant state
  logic [COORD_BITS-1:0]       held_center_x;
  logic [COORD_BITS-1:0]       held_center_y;
  logic [acr_pkg::COLOR_W-1:0] held_color;
  logic [COORD_BITS-1:0]       step_x;
  logic [COORD_BITS-1:0]       step_y;
  logic signed [DW-1:0]        decision_term;
  logic signed [DW-1:0]        incr_x;
  logic signed [DW-1:0]        incr_y;
  logic                        active;

  // sequencer bookkeeping
  logic                          start_mode;
  logic                          fin;
  logic [acr_pkg::PT_IDX_W-1:0]  idx;
  logic                          scl_go;
  logic                          scl_go_next;
  logic [COORD_BITS-1:0]         hx;
  logic [COORD_BITS-1:0]         hy;

  // octant update
  logic                  y_dec;
  logic [COORD_BITS-1:0] step_x_next;
  logic [COORD_BITS-1:0] step_y_next;
  logic signed [DW-1:0]  incr_x_next;
  logic signed [DW-1:0]  incr_y_next;
  logic signed [DW-1:0]  decision_mid;
  logic signed [DW-1:0]  decision_next;
  logic                  done_next;

  logic [COORD_BITS-1:0] in_cx;
  logic [COORD_BITS-1:0] in_cy;
  logic [COORD_BITS-1:0] in_r;
  logic                  item_take;

  acr_pkg::scl_stat_t    scl_stat;
  logic [COORD_BITS-1:0] scl_result;
  logic [COORD_BITS-1:0] scl_operand;
  acr_pkg::pt_ctrl_t     pt_ctrl;
  logic                  pt_free;
  logic [acr_pkg::PT_IDX_W-1:0] last_idx;

  // ---------------- config port ----------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      aspect_mult <= '0;
      aspect_div  <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        acr_pkg::CFG_ASPECT_MULT: aspect_mult <= cfg.data;
        acr_pkg::CFG_ASPECT_DIV:  aspect_div  <= cfg.data;
        default: ;
      endcase
    end
  end

  // ---------------- item intake ----------------
  assign item.ready = (state == ST_IDLE);
  assign item_take  = item.valid && item.ready;

  // fields taken modulo 2^COORD_BITS
  assign in_cx = COORD_BITS'(item.center_x);
  assign in_cy = COORD_BITS'(item.center_y);
  assign in_r  = COORD_BITS'(item.radius);

  // one midpoint step: y moves first when decision is non-negative
  always_comb begin
    y_dec         = !decision_term[DW-1];
    step_x_next   = step_x + COORD_BITS'(1);
    step_y_next   = y_dec ? step_y - COORD_BITS'(1) : step_y;
    incr_x_next   = incr_x + DW'(acr_pkg::INCR_STEP);
    incr_y_next   = y_dec ? incr_y + DW'(acr_pkg::INCR_STEP) : incr_y;
    decision_mid  = y_dec ? decision_term + incr_y_next : decision_term;
    decision_next = decision_mid + incr_x_next;
    done_next     = (step_x_next >= step_y_next);
  end

  // ---------------- sequencer ----------------
  assign last_idx = start_mode ? acr_pkg::START_LAST_IDX : acr_pkg::STEP_LAST_IDX;

  // scaler launch: on a start or a live step, and again after the first offset
  assign scl_go_next = (state == ST_IDLE && item_take &&
                        (item.operation == acr_pkg::OP_START || active)) ||
                       (state == ST_SCALE_H && scl_stat.done);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      held_center_x <= '0;
      held_center_y <= '0;
      held_color    <= '0;
      step_x        <= '0;
      step_y        <= '0;
      decision_term <= '0;
      incr_x        <= DW'(1);
      incr_y        <= '0;
      active        <= 1'b0;
      start_mode    <= 1'b0;
      fin           <= 1'b0;
      idx           <= '0;
      scl_go        <= 1'b0;
    end else begin
      scl_go <= scl_go_next;
      case (state)
        ST_IDLE: begin
          if (item_take) begin
            if (item.operation == acr_pkg::OP_START) begin
              held_center_x <= in_cx;
              held_center_y <= in_cy;
              held_color    <= item.color;
              step_x        <= '0;
              step_y        <= in_r;
              decision_term <= DW'(acr_pkg::DECIS_INIT) - DW'(in_r);
              incr_x        <= DW'(1);
              incr_y        <= DW'(0) - (DW'(in_r) << 1);
              active        <= (in_r != '0);
              fin           <= (in_r == '0);
              start_mode    <= 1'b1;
              state         <= ST_SCALE_V;
            end else if (active) begin
              step_x        <= step_x_next;
              step_y        <= step_y_next;
              decision_term <= decision_next;
              incr_x        <= incr_x_next;
              incr_y        <= incr_y_next;
              active        <= !done_next;
              fin           <= done_next;
              start_mode    <= 1'b0;
              state         <= ST_SCALE_H;
            end
          end
        end
        ST_SCALE_H: begin
          if (scl_stat.done) begin
            state <= ST_SCALE_V;
          end
        end
        ST_SCALE_V: begin
          if (scl_stat.done) begin
            idx   <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (pt_free) begin
            idx <= idx + acr_pkg::PT_IDX_W'(1);
            if (idx == last_idx) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // scaled offsets: hx from step_x, hy from step_y (radius on start)
  always_ff @(posedge clk) begin
    if (scl_stat.done && state == ST_SCALE_H) begin
      hx <= scl_result;
    end
    if (scl_stat.done && state == ST_SCALE_V) begin
      hy <= scl_result;
    end
  end

  // ---------------- shared scaler ----------------
  assign scl_operand = (state == ST_SCALE_H) ? step_x : step_y;

  acr_scaler #(
    .COORD_BITS (COORD_BITS)
  ) u_scaler (
    .clk     (clk),
    .rst     (rst),
    .start   (scl_go),
    .operand (scl_operand),
    .mult    (aspect_mult),
    .div     (aspect_div),
    .stat    (scl_stat),
    .result  (scl_result)
  );

  // ---------------- point output ----------------
  assign pt_ctrl.load       = (state == ST_EMIT) && pt_free;
  assign pt_ctrl.start_mode = start_mode;
  assign pt_ctrl.idx        = idx;
  assign pt_ctrl.last       = (idx == last_idx);
  assign pt_ctrl.done       = (idx == last_idx) && fin;

  acr_point_out #(
    .COORD_BITS (COORD_BITS)
  ) u_point_out (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (pt_ctrl),
    .cx    (held_center_x),
    .cy    (held_center_y),
    .hx    (hx),
    .hy    (hy),
    .vx    (step_x),
    .vy    (step_y),
    .color (held_color),
    .free  (pt_free),
    .point (point)
  );

  `ACR_ASSERT_NXT(a_last_load_idle, pt_ctrl.load && pt_ctrl.last, state == ST_IDLE)
  `ACR_ASSERT_IMP(a_done_inactive, pt_ctrl.load && pt_ctrl.done, !active)
  `ACR_ASSERT_IMP(a_scaler_owned, scl_stat.done, state == ST_SCALE_H || state == ST_SCALE_V)
  `ACR_ASSERT_IMP(a_scaler_idle, state == ST_IDLE, !scl_stat.busy)

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for aspect_circle_rasterizer: circle point scoreboard plus drivers.
// Depends on acr_pkg, acr_ifs and the rasterizer RTL; reads no files.
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [acr_pkg::POINT_W-1:0] x;
  logic signed [acr_pkg::POINT_W-1:0] y;
  logic [acr_pkg::COLOR_W-1:0]        color;
  logic                               last;
  logic                               done;
} circle_point_t;

// Tracks the octant walk of the circle in progress and queues the points it
// should produce, then matches the block's points against them in order.
class circle_scoreboard;
  logic [acr_pkg::CFG_W-1:0]   aspect_num;
  logic [acr_pkg::CFG_W-1:0]   aspect_den;
  int                          cen_x;
  int                          cen_y;
  logic [acr_pkg::COLOR_W-1:0] hue;
  int                          ox;
  int                          oy;
  int                          decision;
  int                          dx;
  int                          dy;
  bit                          running;
  circle_point_t               expected_points[$];
  int                          errors;
  int                          checked;
  int                          starts;
  int                          steps;
  int                          ignored;

  function new();
    aspect_num = '0;
    aspect_den = '0;
    cen_x      = 0;
    cen_y      = 0;
    hue        = '0;
    ox         = 0;
    oy         = 0;
    decision   = 0;
    dx         = 1;
    dy         = 0;
    running    = 1'b0;
    errors     = 0;
    checked    = 0;
    starts     = 0;
    steps      = 0;
    ignored    = 0;
  endfunction

  function void set_reg(logic [acr_pkg::CFG_IDX_W-1:0] idx, logic [acr_pkg::CFG_W-1:0] data);
    case (idx)
      acr_pkg::CFG_ASPECT_MULT: aspect_num = data;
      acr_pkg::CFG_ASPECT_DIV:  aspect_den = data;
      default: ;
    endcase
  endfunction

  // horizontal compression, truncating; off is never negative
  function int scaled(int off);
    if (aspect_num != 0 && aspect_den > aspect_num)
      return (off * int'(aspect_num)) / int'(aspect_den);
    return off;
  endfunction

  function void push_point(int px, int py, bit last, bit done);
    circle_point_t p;
    p.x     = px[acr_pkg::POINT_W-1:0];
    p.y     = py[acr_pkg::POINT_W-1:0];
    p.color = hue;
    p.last  = last;
    p.done  = done;
    expected_points.push_back(p);
  endfunction

  // Called once per accepted transaction; returns how many points it causes.
  function int plot_item(logic op, logic [7:0] cx, logic [7:0] cy, logic [7:0] r,
                         logic [3:0] col);
    int hx;
    int hy;
    bit done;
    if (op == acr_pkg::OP_START) begin
      starts++;
      cen_x    = int'(cx);
      cen_y    = int'(cy);
      hue      = col;
      ox       = 0;
      oy       = int'(r);
      decision = acr_pkg::DECIS_INIT - oy;
      dx       = 1;
      dy       = -acr_pkg::INCR_STEP * oy;
      running  = (oy > 0);
      hy       = scaled(oy);
      push_point(cen_x, cen_y + oy, 1'b0, 1'b0);
      push_point(cen_x, cen_y - oy, 1'b0, 1'b0);
      push_point(cen_x + hy, cen_y, 1'b0, 1'b0);
      push_point(cen_x - hy, cen_y, 1'b1, !running);
      return 4;
    end
    if (!running) begin
      ignored++;
      return 0;
    end
    steps++;
    if (decision >= 0) begin
      oy--;
      dy += acr_pkg::INCR_STEP;
      decision += dy;
    end
    ox++;
    dx += acr_pkg::INCR_STEP;
    decision += dx;
    hx   = scaled(ox);
    hy   = scaled(oy);
    done = (ox >= oy);
    if (done)
      running = 1'b0;
    push_point(cen_x + hx, cen_y + oy, 1'b0, 1'b0);
    push_point(cen_x - hx, cen_y + oy, 1'b0, 1'b0);
    push_point(cen_x + hx, cen_y - oy, 1'b0, 1'b0);
    push_point(cen_x - hx, cen_y - oy, 1'b0, 1'b0);
    push_point(cen_x + hy, cen_y + ox, 1'b0, 1'b0);
    push_point(cen_x - hy, cen_y + ox, 1'b0, 1'b0);
    push_point(cen_x + hy, cen_y - ox, 1'b0, 1'b0);
    push_point(cen_x - hy, cen_y - ox, 1'b1, done);
    return 8;
  endfunction

  function void report(string field, int want, int got);
    $display("%0t: point %0d field %s mismatch: expected %0d actual %0d",
             $time, checked, field, want, got);
    errors++;
  endfunction

  function void check_point(logic signed [acr_pkg::POINT_W-1:0] px,
                            logic signed [acr_pkg::POINT_W-1:0] py,
                            logic [acr_pkg::COLOR_W-1:0] pc, logic pl, logic pd);
    circle_point_t want;
    if (expected_points.size() == 0) begin
      $display("%0t: unexpected point x=%0d y=%0d color=%0d", $time, px, py, pc);
      errors++;
      return;
    end
    want = expected_points.pop_front();
    checked++;
    if (px !== want.x) report("point_x", int'(want.x), int'(px));
    if (py !== want.y) report("point_y", int'(want.y), int'(py));
    if (pc !== want.color) report("point_color", int'(want.color), int'(pc));
    if (pl !== want.last) report("last_of_run", int'(want.last), int'(pl));
    if (pd !== want.done) report("circle_done", int'(want.done), int'(pd));
  endfunction
endclass

module tb_top;

  localparam int CLK_PERIOD    = 20;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 64;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_BUDGET  = 12;   // transactions that produce points, per phase

  typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_PERIODIC, SINK_BURSTY} sink_mode_e;

  typedef struct {
    logic [acr_pkg::CFG_W-1:0] num;
    logic [acr_pkg::CFG_W-1:0] den;
    sink_mode_e                sink;
    int                        gap_max;
  } phase_t;

  logic clk = 1'b0;
  logic rst;

  acr_cfg_if   cfg_bus();
  acr_item_if  circle_bus();
  acr_point_if point_bus();

  aspect_circle_rasterizer i_dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_bus),
    .item  (circle_bus),
    .point (point_bus)
  );

  circle_scoreboard sb = new();

  int         cycles = 0;
  int         useful_items = 0;   // accepted transactions that produced points
  int         burst_left = 0;
  int         gap_max = 0;
  int         sink_hold = 0;
  sink_mode_e sink_mode = SINK_ALWAYS;
  phase_t     plan[NUM_PHASES];

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Point sink: ready pattern changes from phase to phase.
  always @(negedge clk) begin
    case (sink_mode)
      SINK_ALWAYS:   point_bus.ready <= 1'b1;
      SINK_RANDOM:   point_bus.ready <= ($urandom_range(0, 99) >= 35);
      SINK_PERIODIC: point_bus.ready <= ((cycles % 7) >= 3);
      default: begin
        // mostly ready, with occasional random stalls
        if (sink_hold == 0 && $urandom_range(0, 9) == 0)
          sink_hold = $urandom_range(2, 8);
        if (sink_hold != 0) begin
          sink_hold--;
          point_bus.ready <= 1'b0;
        end else begin
          point_bus.ready <= 1'b1;
        end
      end
    endcase
  end

  // Point checker and watchdog. Outputs are sampled at the rising edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d points still pending",
               $time, CYCLE_LIMIT, sb.expected_points.size());
      $display("CHECKS FAILED");
      $finish;
    end else if (!rst && point_bus.valid && point_bus.ready) begin
      sb.check_point(point_bus.point_x, point_bus.point_y, point_bus.point_color,
                     point_bus.last_of_run, point_bus.circle_done);
    end
  end

  // One circle transaction. The sender runs in bursts; between bursts valid
  // may drop for a random gap. valid stays high across back-to-back
  // transactions inside a burst.
  task automatic send_item(input logic op, input logic [7:0] cx, input logic [7:0] cy,
                           input logic [7:0] r, input logic [3:0] col);
    int gap;
    int produced;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk);
        circle_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    circle_bus.valid     <= 1'b1;
    circle_bus.operation <= op;
    circle_bus.center_x  <= cx;
    circle_bus.center_y  <= cy;
    circle_bus.radius    <= r;
    circle_bus.color     <= col;
    do @(posedge clk); while (!circle_bus.ready);
    produced = sb.plot_item(op, cx, cy, r, col);
    if (produced != 0)
      useful_items++;
  endtask

  // step transactions carry junk in the unused fields
  task automatic send_step();
    send_item(acr_pkg::OP_STEP, 8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom));
  endtask

  task automatic draw_circle(input logic [7:0] cx, input logic [7:0] cy, input logic [7:0] r,
                             input logic [3:0] col, input int nsteps);
    send_item(acr_pkg::OP_START, cx, cy, r, col);
    repeat (nsteps) send_step();
  endtask

  task automatic write_reg(input logic [acr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [acr_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Drop valid, let every expected point come out, then allow for a trailing
  // step that produces nothing but may still be in flight.
  task automatic settle();
    @(negedge clk);
    circle_bus.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly whole circles with random content walked until done; some are cut
  // short or restarted, some get a trailing step, and a few items are noise.
  task automatic random_phase(input int budget);
    int       target;
    int       cap;
    int       n;
    logic [7:0] r;
    target = useful_items + budget;
    while (useful_items < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom));
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          r   = 8'($urandom_range(0, 255));
          cap = 16;     // big circles are left unfinished most of the time
        end else begin
          r   = 8'($urandom_range(0, 16));
          cap = 200;
        end
        if ($urandom_range(0, 5) == 0)
          cap = $urandom_range(0, 4);   // broken sequence: abandoned early
        send_item(acr_pkg::OP_START, 8'($urandom), 8'($urandom), r, 4'($urandom));
        n = 0;
        while (sb.running && n < cap) begin
          send_step();
          n++;
        end
        if ($urandom_range(0, 2) == 0)
          send_step();
      end
    end
  endtask

  initial begin
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = '0;
    cfg_bus.data         = '0;
    circle_bus.valid     = 1'b0;
    circle_bus.operation = acr_pkg::OP_START;
    circle_bus.center_x  = '0;
    circle_bus.center_y  = '0;
    circle_bus.radius    = '0;
    circle_bus.color     = '0;
    point_bus.ready      = 1'b0;
    rst                  = 1'b1;

    // aspect settings: disabled cases (zero numerator, div not above mult),
    // the extremes of compression and random ones
    plan[0] = '{8'd0,   8'd0,   SINK_RANDOM,   3};
    plan[1] = '{8'd255, 8'd0,   SINK_RANDOM,   4};
    plan[2] = '{8'd1,   8'd255, SINK_PERIODIC, 2};
    plan[3] = '{8'd254, 8'd255, SINK_BURSTY,   6};
    plan[4] = '{8'd0,   8'd255, SINK_RANDOM,   1};
    plan[5] = '{8'd200, 8'd200, SINK_ALWAYS,   0};
    plan[6].num = 8'($urandom_range(1, 254));
    plan[6].den = 8'($urandom_range(int'(plan[6].num) + 1, 255));
    plan[6].sink = SINK_BURSTY;
    plan[6].gap_max = 5;
    plan[7] = '{8'($urandom), 8'($urandom), SINK_PERIODIC, 3};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sink_mode = plan[0].sink;
    gap_max   = plan[0].gap_max;

    // Directed part under the reset configuration (no scaling).
    send_item(acr_pkg::OP_STEP, 8'hFF, 8'hFF, 8'hFF, 4'hF);  // no circle yet: ignored
    draw_circle(8'h00, 8'h00, 8'h00, 4'h0, 1);   // zero radius done at once, step ignored
    draw_circle(8'hFF, 8'hFF, 8'hFF, 4'hF, 3);   // far edge, coordinates up to 510
    draw_circle(8'h00, 8'h00, 8'hFF, 4'h5, 2);   // negative coordinates
    draw_circle(8'd100, 8'd60, 8'd1, 4'h9, 2);   // done on first step, then ignored
    draw_circle(8'd128, 8'd128, 8'd5, 4'hA, 5);  // full octant plus a step after done
    draw_circle(8'd40, 8'd200, 8'd3, 4'h3, 1);   // abandoned by a new start
    draw_circle(8'd41, 8'd201, 8'd2, 4'h6, 3);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        settle();
        write_reg(acr_pkg::CFG_ASPECT_MULT, plan[p].num);
        write_reg(acr_pkg::CFG_ASPECT_DIV, plan[p].den);
        sink_mode = plan[p].sink;
        gap_max   = plan[p].gap_max;
      end
      random_phase(PHASE_BUDGET);
    end

    settle();

    $display("Coverage: %0d starts, %0d octant steps, %0d ignored steps, %0d aspect settings",
             sb.starts, sb.steps, sb.ignored, NUM_PHASES);
    $display("Compared %0d points, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.expected_points.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
